// ----- hw/rtl/mrq_pkg.sv -----
package mrq_pkg;

  localparam int unsigned MoveW  = 8;
  localparam int unsigned StepW  = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_HALF_STEP_TICKS  = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_GAP_TICKS        = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_STEPS_PER_REPORT = 2'd2;

  localparam logic [TickW-1:0] HALF_STEP_TICKS_RST  = 16'd50;
  localparam logic [TickW-1:0] GAP_TICKS_RST        = 16'd500;
  localparam logic [StepW-1:0] STEPS_PER_REPORT_RST = 7'd100;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_STEP = 3'b010,
    MODE_GAP  = 3'b100
  } mode_e;

  typedef struct packed {
    logic h_pulse;
    logic h_quad;
    logic v_pulse;
    logic v_quad;
    logic left_line;
    logic right_line;
    logic busy_res;
    logic report_dropped;
  } out_beat_t;

endpackage

// ----- hw/rtl/mrq_if.sv -----
interface mrq_in_if;
  import mrq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic                    left_pressed;
  logic                    right_pressed;
  logic signed [MoveW-1:0] move_x;
  logic signed [MoveW-1:0] move_y;

  modport source (output valid, command, left_pressed, right_pressed, move_x, move_y,
                  input ready);
  modport sink (input valid, command, left_pressed, right_pressed, move_x, move_y,
                output ready);
endinterface

interface mrq_out_if;
  logic valid;
  logic ready;
  logic h_pulse;
  logic h_quad;
  logic v_pulse;
  logic v_quad;
  logic left_line;
  logic right_line;
  logic busy_res;
  logic report_dropped;

  modport source (output valid, h_pulse, h_quad, v_pulse, v_quad, left_line, right_line,
                  busy_res, report_dropped, input ready);
  modport sink (input valid, h_pulse, h_quad, v_pulse, v_quad, left_line, right_line,
                busy_res, report_dropped, output ready);
endinterface

interface mrq_cfg_if;
  import mrq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/mrq_out_buf.sv -----
module mrq_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  mrq_pkg::out_beat_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output mrq_pkg::out_beat_t pop_data_o
);
  import mrq_pkg::*;

  out_beat_t head_q, skid_q;
  logic      head_valid_q, skid_valid_q;
  logic      push, head_free;

  // The skid entry lets a new beat in while the head beat is stalled.
  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign head_free    = !head_valid_q || pop_ready_i;
  assign pop_valid_o  = head_valid_q;
  assign pop_data_o   = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (head_free) begin
      head_valid_q <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_free) begin
      head_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/mouse_report_to_quadrature_core.sv -----
// Mouse report to quadrature pulse generator.
// in_ch carries commands: a report (buttons and signed X/Y moves) or a one-time
// tick. Every accepted beat yields exactly one beat on out_ch holding the phase
// pin levels, the active-low button pins, a busy flag and a dropped-report flag.
// A report starts a run of steps_per_report full steps; ticks count out the wait
// after each half-step and the gap after the last step. A report that arrives
// while a run or gap is in progress is dropped and flagged.
// cfg_ch writes the three timing registers by index; it is always ready and is
// meant to be written only while the block is idle.
// The result of an accepted beat is registered in the output buffer head, or
// in its skid entry while out_ch is stalled. Throughput is one beat per cycle
// while out_ch takes results, set by the single state update before the buffer.
// A two-entry output buffer keeps in_ch ready for one more beat while out_ch is
// stalled; with both entries full in_ch.ready drops until a result is taken.
// Reset puts all phase pins high, both button pins low, the block idle and the
// registers at 50, 500 and 100.
module mouse_report_to_quadrature_core (
  input logic       clk_i,
  input logic       rst_ni,
  mrq_in_if.sink    in_ch,
  mrq_out_if.source out_ch,
  mrq_cfg_if.sink   cfg_ch
);
  import mrq_pkg::*;

  logic [TickW-1:0] half_ticks_q, gap_ticks_q;
  logic [StepW-1:0] steps_q;

  logic [3:0]       pins_q, pins_d;
  logic [1:0]       buttons_q, buttons_d;
  logic [StepW-1:0] x_mag_q, x_mag_d, y_mag_q, y_mag_d;
  logic             x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [StepW-1:0] step_q, step_d, step_next;
  logic             half_q, half_d;
  logic [TickW-1:0] wait_q, wait_d, wait_dec, half_wait;
  mode_e            mode_q, mode_d;

  logic             in_accept, in_ready, dropped;
  out_beat_t        beat;

  function automatic logic [StepW-1:0] cap_move(logic [MoveW-1:0] v, logic [StepW-1:0] cap);
    logic [MoveW-1:0] mag;
    mag = v[MoveW-1] ? (~v + MoveW'(1)) : v;
    return (mag > MoveW'(cap)) ? cap : mag[StepW-1:0];
  endfunction

  // pins bit 0/1 are the horizontal A/B pins, bits 2/3 the vertical ones.
  function automatic logic [3:0] half_step(logic [3:0] p, logic second, logic [StepW-1:0] idx,
                                           logic [StepW-1:0] xm, logic xn,
                                           logic [StepW-1:0] ym, logic yn);
    logic [3:0] r;
    r = p;
    if (idx < xm) begin
      if (second ^ xn) r[1] = ~r[1];
      else r[0] = ~r[0];
    end
    if (idx < ym) begin
      if (second ^ yn) r[3] = ~r[3];
      else r[2] = ~r[2];
    end
    return r;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign in_accept    = in_ch.valid && in_ready;
  assign half_wait    = (half_ticks_q == '0) ? TickW'(1) : half_ticks_q;
  assign wait_dec     = (wait_q != '0) ? wait_q - TickW'(1) : wait_q;
  assign step_next    = step_q + StepW'(1);

  always_comb begin
    pins_d    = pins_q;
    buttons_d = buttons_q;
    x_mag_d   = x_mag_q;
    x_neg_d   = x_neg_q;
    y_mag_d   = y_mag_q;
    y_neg_d   = y_neg_q;
    step_d    = step_q;
    half_d    = half_q;
    wait_d    = wait_q;
    mode_d    = mode_q;
    dropped   = 1'b0;
    if (in_accept) begin
      if (in_ch.command == CMD_REPORT) begin
        if (mode_q != MODE_IDLE) begin
          dropped = 1'b1;
        end else begin
          buttons_d = {~in_ch.right_pressed, ~in_ch.left_pressed};
          x_mag_d   = cap_move(in_ch.move_x, steps_q);
          x_neg_d   = in_ch.move_x[MoveW-1];
          y_mag_d   = cap_move(in_ch.move_y, steps_q);
          y_neg_d   = in_ch.move_y[MoveW-1];
          step_d    = '0;
          half_d    = 1'b0;
          if (steps_q == '0) begin
            mode_d = (gap_ticks_q == '0) ? MODE_IDLE : MODE_GAP;
            wait_d = gap_ticks_q;
          end else begin
            pins_d = half_step(pins_q, 1'b0, '0, x_mag_d, x_neg_d, y_mag_d, y_neg_d);
            mode_d = MODE_STEP;
            wait_d = half_wait;
          end
        end
      end else if (mode_q != MODE_IDLE) begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          if (mode_q == MODE_GAP) begin
            mode_d = MODE_IDLE;
          end else if (!half_q) begin
            pins_d = half_step(pins_q, 1'b1, step_q, x_mag_q, x_neg_q, y_mag_q, y_neg_q);
            half_d = 1'b1;
            wait_d = half_wait;
          end else begin
            half_d = 1'b0;
            step_d = step_next;
            // The step counter wraps at its width, which also ends the run.
            if (step_next == '0 || step_next >= steps_q) begin
              mode_d = (gap_ticks_q == '0) ? MODE_IDLE : MODE_GAP;
              wait_d = gap_ticks_q;
            end else begin
              pins_d = half_step(pins_q, 1'b0, step_next, x_mag_q, x_neg_q, y_mag_q, y_neg_q);
              wait_d = half_wait;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_ticks_q <= HALF_STEP_TICKS_RST;
      gap_ticks_q  <= GAP_TICKS_RST;
      steps_q      <= STEPS_PER_REPORT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_HALF_STEP_TICKS:  half_ticks_q <= cfg_ch.data[TickW-1:0];
        CFG_GAP_TICKS:        gap_ticks_q  <= cfg_ch.data[TickW-1:0];
        CFG_STEPS_PER_REPORT: steps_q      <= cfg_ch.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q    <= 4'hF;
      buttons_q <= '0;
      x_mag_q   <= '0;
      x_neg_q   <= 1'b0;
      y_mag_q   <= '0;
      y_neg_q   <= 1'b0;
      step_q    <= '0;
      half_q    <= 1'b0;
      wait_q    <= '0;
      mode_q    <= MODE_IDLE;
    end else begin
      pins_q    <= pins_d;
      buttons_q <= buttons_d;
      x_mag_q   <= x_mag_d;
      x_neg_q   <= x_neg_d;
      y_mag_q   <= y_mag_d;
      y_neg_q   <= y_neg_d;
      step_q    <= step_d;
      half_q    <= half_d;
      wait_q    <= wait_d;
      mode_q    <= mode_d;
    end
  end

  always_comb begin
    beat.h_pulse        = pins_d[0];
    beat.h_quad         = pins_d[1];
    beat.v_pulse        = pins_d[2];
    beat.v_quad         = pins_d[3];
    beat.left_line      = buttons_d[0];
    beat.right_line     = buttons_d[1];
    beat.busy_res       = (mode_d != MODE_IDLE);
    beat.report_dropped = dropped;
  end

  out_beat_t res;

  mrq_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_ch.valid),
    .push_ready_o (in_ready),
    .push_data_i  (beat),
    .pop_valid_o  (out_ch.valid),
    .pop_ready_i  (out_ch.ready),
    .pop_data_o   (res)
  );

  assign out_ch.h_pulse        = res.h_pulse;
  assign out_ch.h_quad         = res.h_quad;
  assign out_ch.v_pulse        = res.v_pulse;
  assign out_ch.v_quad         = res.v_quad;
  assign out_ch.left_line      = res.left_line;
  assign out_ch.right_line     = res.right_line;
  assign out_ch.busy_res       = res.busy_res;
  assign out_ch.report_dropped = res.report_dropped;

endmodule

// ----- hw/rtl/mrq_checker.sv -----
module mrq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_busy_i,
  input logic out_dropped_i
);

  // A dropped report leaves the run going, so the same beat must show busy.
  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_dropped_i |-> out_busy_i)
    else $error("dropped report shown while not busy");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted beat produced no result");

  // Back pressure on the input only comes from a full output buffer.
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result withdrawn");

endmodule

bind mouse_report_to_quadrature_core mrq_checker u_mrq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_busy_i    (out_ch.busy_res),
  .out_dropped_i (out_ch.report_dropped)
);

// ----- tb/mouse_report_to_quadrature_core_tb.sv -----
module mouse_report_to_quadrature_core_tb;
  import mrq_pkg::*;

  localparam logic [CfgAddrW-1:0] CFG_SPARE = 2'd3;
  localparam logic [3:0] PIN_HA = 4'b0001;
  localparam logic [3:0] PIN_HB = 4'b0010;
  localparam logic [3:0] PIN_VA = 4'b0100;
  localparam logic [3:0] PIN_VB = 4'b1000;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned ITEM_TARGET = 600;

  typedef struct packed {
    logic                    command;
    logic                    left_pressed;
    logic                    right_pressed;
    logic signed [MoveW-1:0] move_x;
    logic signed [MoveW-1:0] move_y;
  } cmd_beat_t;

  class quad_scoreboard;
    logic [TickW-1:0] half_ticks;
    logic [TickW-1:0] gap_len;
    logic [StepW-1:0] steps;
    logic [3:0]       pins;
    logic [1:0]       buttons;
    logic [MoveW-1:0] mag_x;
    logic [MoveW-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic [StepW-1:0] step_idx;
    logic             second_half;
    logic [TickW-1:0] wait_left;
    mode_e            mode;
    out_beat_t        pin_levels_q[$];
    string            field_names[8];
    int               errors, checked, reports, dropped, ticks, runs_done;

    function new();
      field_names = '{"h_pulse", "h_quad", "v_pulse", "v_quad",
                      "left_line", "right_line", "busy_res", "report_dropped"};
      half_ticks  = HALF_STEP_TICKS_RST;
      gap_len     = GAP_TICKS_RST;
      steps       = STEPS_PER_REPORT_RST;
      pins        = '1;
      buttons     = '0;
      mag_x       = '0;
      mag_y       = '0;
      neg_x       = 1'b0;
      neg_y       = 1'b0;
      step_idx    = '0;
      second_half = 1'b0;
      wait_left   = '0;
      mode        = MODE_IDLE;
      errors      = 0;
      checked     = 0;
      reports     = 0;
      dropped     = 0;
      ticks       = 0;
      runs_done   = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_HALF_STEP_TICKS:  half_ticks = val;
        CFG_GAP_TICKS:        gap_len = val;
        CFG_STEPS_PER_REPORT: steps = val[StepW-1:0];
        default: ;
      endcase
    endfunction

    function bit running();
      return mode != MODE_IDLE;
    endfunction

    function bit pending();
      return pin_levels_q.size() != 0;
    endfunction

    function logic [MoveW-1:0] capped_magnitude(logic [MoveW-1:0] mv);
      logic [MoveW-1:0] m;
      // The negation of -128 gives 128, which still fits as an unsigned byte.
      m = mv[MoveW-1] ? -mv : mv;
      return (m > {1'b0, steps}) ? {1'b0, steps} : m;
    endfunction

    // The first half-step toggles the leading pin, the second the lagging one;
    // a negative move swaps which pin leads.
    function void half_step(logic second);
      if ({1'b0, step_idx} < mag_x) pins ^= (second ^ neg_x) ? PIN_HB : PIN_HA;
      if ({1'b0, step_idx} < mag_y) pins ^= (second ^ neg_y) ? PIN_VB : PIN_VA;
    endfunction

    function logic [TickW-1:0] half_wait();
      return (half_ticks == 0) ? TickW'(1) : half_ticks;
    endfunction

    function void start_gap();
      if (gap_len == 0) begin
        mode = MODE_IDLE;
        wait_left = '0;
        runs_done++;
      end else begin
        mode = MODE_GAP;
        wait_left = gap_len;
      end
    endfunction

    function void note_command(cmd_beat_t c);
      out_beat_t exp_b;
      logic      dropped_now;
      dropped_now = 1'b0;
      if (c.command == CMD_REPORT) begin
        reports++;
        if (mode != MODE_IDLE) begin
          dropped_now = 1'b1;
          dropped++;
        end else begin
          buttons     = {~c.right_pressed, ~c.left_pressed};
          neg_x       = c.move_x[MoveW-1];
          neg_y       = c.move_y[MoveW-1];
          mag_x       = capped_magnitude(c.move_x);
          mag_y       = capped_magnitude(c.move_y);
          step_idx    = '0;
          second_half = 1'b0;
          if (steps == 0) begin
            start_gap();
          end else begin
            half_step(1'b0);
            mode      = MODE_STEP;
            wait_left = half_wait();
          end
        end
      end else begin
        ticks++;
        if (mode != MODE_IDLE) begin
          if (wait_left > 0) wait_left--;
          if (wait_left == 0) begin
            if (mode == MODE_GAP) begin
              mode = MODE_IDLE;
              runs_done++;
            end else if (!second_half) begin
              half_step(1'b1);
              second_half = 1'b1;
              wait_left   = half_wait();
            end else begin
              second_half = 1'b0;
              step_idx++;
              if (step_idx == 0 || step_idx >= steps) begin
                start_gap();
              end else begin
                half_step(1'b0);
                wait_left = half_wait();
              end
            end
          end
        end
      end
      exp_b.h_pulse        = pins[0];
      exp_b.h_quad         = pins[1];
      exp_b.v_pulse        = pins[2];
      exp_b.v_quad         = pins[3];
      exp_b.left_line      = buttons[0];
      exp_b.right_line     = buttons[1];
      exp_b.busy_res       = (mode != MODE_IDLE);
      exp_b.report_dropped = dropped_now;
      pin_levels_q.push_back(exp_b);
    endfunction

    function void check_pins(out_beat_t got);
      out_beat_t exp_b;
      checked++;
      if (pin_levels_q.size() == 0) begin
        errors++;
        $display("%0t: result %b arrived with nothing expected", $time, got);
        return;
      end
      exp_b = pin_levels_q.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got[7-i] !== exp_b[7-i]) begin
          errors++;
          $display("%0t: %s expected %0b got %0b", $time, field_names[i],
                   exp_b[7-i], got[7-i]);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mrq_in_if  in_ch();
  mrq_out_if out_ch();
  mrq_cfg_if cfg_ch();

  mouse_report_to_quadrature_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  quad_scoreboard sb;
  bit             calm;
  int unsigned    ready_hold;
  int unsigned    ready_pick;
  int unsigned    cycles;
  int unsigned    items_sent;
  out_beat_t      seen;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: mostly ready, with short stalls and the odd long one.
  always @(negedge clk_i) begin
    if (calm) begin
      out_ch.ready = 1'b1;
    end else if (ready_hold == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 70) begin
        out_ch.ready = 1'b1;
        ready_hold = $urandom_range(1, 8);
      end else if (ready_pick < 95) begin
        out_ch.ready = 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        out_ch.ready = 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end else begin
      ready_hold--;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("mouse_report_to_quadrature_core test failed");
      $finish;
    end else if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.h_pulse, out_ch.h_quad, out_ch.v_pulse, out_ch.v_quad,
              out_ch.left_line, out_ch.right_line, out_ch.busy_res, out_ch.report_dropped};
      sb.check_pins(seen);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [MoveW-1:0] pick_move();
    int unsigned r;
    int          lim;
    int          m;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return MoveW'(-128);
        1:       return MoveW'(127);
        2:       return '0;
        3:       return MoveW'(-1);
        default: return MoveW'(1);
      endcase
    end
    if (r < 60) begin
      lim = (sb.steps + 2 > 127) ? 127 : sb.steps + 2;
      m = $urandom_range(0, lim);
      return MoveW'($urandom_range(0, 1) ? -m : m);
    end
    return MoveW'($urandom);
  endfunction

  // Every field is random; ticks carry random payload the block must ignore.
  function automatic cmd_beat_t random_beat(logic cmd);
    cmd_beat_t c;
    c.command       = cmd;
    c.left_pressed  = 1'($urandom_range(0, 1));
    c.right_pressed = 1'($urandom_range(0, 1));
    c.move_x        = MoveW'($urandom);
    c.move_y        = MoveW'($urandom);
    if (cmd == CMD_REPORT) begin
      c.move_x = pick_move();
      c.move_y = pick_move();
    end
    return c;
  endfunction

  function automatic cmd_beat_t report_beat(logic l, logic r, int x, int y);
    cmd_beat_t c;
    c.command       = CMD_REPORT;
    c.left_pressed  = l;
    c.right_pressed = r;
    c.move_x        = MoveW'(x);
    c.move_y        = MoveW'(y);
    return c;
  endfunction

  task automatic push_cmd(cmd_beat_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid         = 1'b1;
    in_ch.command       = c.command;
    in_ch.left_pressed  = c.left_pressed;
    in_ch.right_pressed = c.right_pressed;
    in_ch.move_x        = c.move_x;
    in_ch.move_y        = c.move_y;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_command(c);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending()) @(posedge clk_i);
  endtask

  // Tick the current run out to idle, then let every result come back.
  task automatic finish_run();
    while (sb.running()) push_cmd(random_beat(CMD_TICK));
    wait_drained();
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = idx;
    cfg_ch.data  = CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, CfgDataW'(val));
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic random_config();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    finish_run();
    if (kind < 6) begin
      write_reg(CFG_HALF_STEP_TICKS, $urandom_range(0, 3));
      write_reg(CFG_STEPS_PER_REPORT, $urandom_range(0, 8));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_GAP_TICKS, $urandom_range(0, 5));
    end else if (kind < 8) begin
      write_reg(CFG_HALF_STEP_TICKS, $urandom_range(0, 1));
      write_reg(CFG_STEPS_PER_REPORT, $urandom_range(100, 127));
      write_reg(CFG_GAP_TICKS, $urandom_range(0, 2));
    end else begin
      write_reg(CFG_HALF_STEP_TICKS, $urandom_range(1, 20));
      write_reg(CFG_STEPS_PER_REPORT, $urandom_range(1, 4));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_GAP_TICKS, $urandom_range(0, 40));
    end
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, $urandom);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly complete runs: a report while idle, then ticks; reports during a run
  // and ticks while idle are the noise.
  task automatic random_phase(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) wait_drained();
      if (sb.running()) push_cmd(random_beat(r < 10 ? CMD_REPORT : CMD_TICK));
      else push_cmd(random_beat(r < 85 ? CMD_REPORT : CMD_TICK));
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_TICK;
    in_ch.left_pressed  = 1'b0;
    in_ch.right_pressed = 1'b0;
    in_ch.move_x        = '0;
    in_ch.move_y        = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_HALF_STEP_TICKS;
    cfg_ch.data         = '0;
    rst_ni              = 1'b0;
    calm                = 1'b0;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: full-scale moves are capped at the default step count.
    push_cmd(report_beat(1'b1, 1'b0, 127, -128));
    push_cmd(random_beat(CMD_TICK));
    push_cmd(report_beat(1'b0, 1'b1, 5, 5));
    // Shrinking the registers mid-run ends the run after its first step.
    wait_drained();
    write_reg(CFG_HALF_STEP_TICKS, 1);
    write_reg(CFG_GAP_TICKS, 0);
    write_reg(CFG_STEPS_PER_REPORT, 1);
    calm = 1'b1;
    finish_run();
    calm = 1'b0;

    // Shortest timing, single step; then a tick while idle.
    write_reg(CFG_HALF_STEP_TICKS, 1);
    write_reg(CFG_GAP_TICKS, 0);
    write_reg(CFG_STEPS_PER_REPORT, 1);
    push_cmd(report_beat(1'b1, 1'b1, -1, 1));
    finish_run();
    push_cmd(random_beat(CMD_TICK));
    wait_drained();

    // A zero half-step wait behaves as one tick.
    write_reg(CFG_HALF_STEP_TICKS, 0);
    write_reg(CFG_GAP_TICKS, 3);
    write_reg(CFG_STEPS_PER_REPORT, 2);
    push_cmd(report_beat(1'b0, 1'b0, -128, 0));
    finish_run();

    // No steps: straight to the gap, then straight to idle with no gap.
    write_reg(CFG_STEPS_PER_REPORT, 0);
    push_cmd(report_beat(1'b0, 1'b1, 5, -5));
    finish_run();
    write_reg(CFG_GAP_TICKS, 0);
    push_cmd(report_beat(1'b1, 1'b0, -7, 7));
    finish_run();
    write_reg(CFG_SPARE, 'hffff);

    write_reg(CFG_HALF_STEP_TICKS, 1);
    write_reg(CFG_STEPS_PER_REPORT, 127);
    push_cmd(report_beat(1'b1, 1'b1, -128, 127));
    finish_run();

    while (items_sent < ITEM_TARGET) begin
      random_config();
      random_phase($urandom_range(40, 120));
    end

    // Largest settings last, since a run there is far too long to finish.
    calm = 1'b0;
    finish_run();
    write_reg(CFG_HALF_STEP_TICKS, 'hffff);
    write_reg(CFG_GAP_TICKS, 'hffff);
    write_reg(CFG_STEPS_PER_REPORT, 127);
    push_cmd(report_beat(1'b0, 1'b0, 127, -1));
    random_phase(40);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d result beats from %0d reports (%0d dropped) and %0d ticks.",
             sb.checked, sb.reports, sb.dropped, sb.ticks);
    $display("%0d pulse runs went back to idle across the register settings.", sb.runs_done);
    if (sb.errors == 0 && !sb.pending()) begin
      $display("mouse_report_to_quadrature_core test passed");
    end else begin
      $display("mouse_report_to_quadrature_core test failed");
    end
    $finish;
  end

endmodule
